// File: hw/rtl/bgc_pkg.sv
`default_nettype none

package bgc_pkg;

    localparam logic [6:0] VC_RESET   = 7'd64;
    localparam logic       KIND_EDGE  = 1'b0;
    localparam logic       KIND_CHECK = 1'b1;

    typedef struct packed {
        logic edge_first;
        logic edge_second;
        logic clr_step;
        logic chk_start;
        logic start_next;
        logic start_visit;
        logic scan_step;
        logic conflict;
        logic pop;
        logic pop_last;
        logic pop_load;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic start_done;
        logic start_skip;
        logic scan_end;
        logic scan_conflict;
        logic depth_one;
        logic out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/bipartite_graph_check.sv
// Bipartite check of an undirected graph held in an adjacency bit matrix.
// Input channel (s_valid/s_ready): an item of kind 0 adds the edge between
// s_first_vertex and s_second_vertex; an item of kind 1 runs the check.
// Result channel (m_valid/m_ready): one item per check, m_is_bipartite.
// cfg_we/cfg_wdata set the vertex count; write it only while the block is idle.
// An edge item makes one adjacency memory write for each direction.
// A check walks the graph depth first, one neighbor index per cycle: each
// visited vertex has its row scanned and is then popped from the stack, and
// each unvisited start vertex begins a new walk; a conflict ends the check.
// After the result is loaded into the output register, the whole adjacency
// memory is cleared, one row per cycle, before s_ready returns.
// After reset the same clearing pass runs with s_ready low; configuration
// writes are taken during it.
// A stalled receiver holds m_valid and the result; the block keeps taking
// edge items meanwhile, and a finished check waits until the slot is free.
`default_nettype none

module bipartite_graph_check
    import bgc_pkg::*;
#(
    parameter int MAX_VERTICES = 64
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        cfg_we,
    input  wire [6:0]  cfg_wdata,
    input  wire        s_valid,
    output logic       s_ready,
    input  wire        s_kind,
    input  wire [5:0]  s_first_vertex,
    input  wire [5:0]  s_second_vertex,
    output logic       m_valid,
    input  wire        m_ready,
    output logic       m_is_bipartite
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    bgc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .status  (status),
        .s_ready (s_ready),
        .cmd     (cmd)
    );

    bgc_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_first_vertex  (s_first_vertex),
        .s_second_vertex (s_second_vertex),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_is_bipartite  (m_is_bipartite)
    );

endmodule

`default_nettype wire

// File: hw/rtl/bgc_ctrl.sv
`default_nettype none

module bgc_ctrl
    import bgc_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    input  wire        s_kind,
    input  dp_status_t status,
    output logic       s_ready,
    output ctrl_cmd_t  cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EDGE2 = 3'd2;
    localparam logic [2:0] ST_START = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_POP   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_kind == KIND_CHECK) begin
                        cmd.chk_start = 1'b1;
                        state_next    = ST_START;
                    end else begin
                        cmd.edge_first = 1'b1;
                        state_next     = ST_EDGE2;
                    end
                end
            end
            ST_EDGE2: begin
                cmd.edge_second = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_START: begin
                priority if (status.start_done) begin
                    state_next = ST_DONE;
                end else if (status.start_skip) begin
                    cmd.start_next = 1'b1;
                end else begin
                    cmd.start_visit = 1'b1;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                priority if (status.scan_end) begin
                    if (status.depth_one) begin
                        cmd.pop_last = 1'b1;
                        state_next   = ST_START;
                    end else begin
                        cmd.pop    = 1'b1;
                        state_next = ST_POP;
                    end
                end else if (status.scan_conflict) begin
                    cmd.conflict = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_POP: begin
                cmd.pop_load = 1'b1;
                state_next   = ST_SCAN;
            end
            ST_DONE: begin
                if (!status.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_CLEAR;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/bgc_dp.sv
`default_nettype none

module bgc_dp
    import bgc_pkg::*;
#(
    parameter int MAX_VERTICES = 64
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status,
    input  wire        cfg_we,
    input  wire [6:0]  cfg_wdata,
    input  wire [5:0]  s_first_vertex,
    input  wire [5:0]  s_second_vertex,
    input  wire        m_ready,
    output logic       m_valid,
    output logic       m_is_bipartite
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam logic [NW-1:0] N_MAX   = NW'(MAX_VERTICES);
    localparam logic [VW-1:0] CLR_END = VW'(MAX_VERTICES - 1);

    typedef struct packed {
        logic [VW-1:0] v;
        logic [NW-1:0] w;
    } stk_entry_t;

    logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
    stk_entry_t              stk_mem [MAX_VERTICES];

    logic [6:0]              vc_reg;
    logic [VW-1:0]           clr_addr_reg;
    logic [NW-1:0]           depth_reg;
    logic                    m_valid_reg;
    logic                    m_valid_next;
    logic [MAX_VERTICES-1:0] row_reg;
    logic [VW-1:0]           e_row_reg;
    logic [VW-1:0]           e_col_reg;
    logic                    e_ok_reg;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [MAX_VERTICES-1:0] color_reg;
    logic [NW-1:0]           start_reg;
    logic [VW-1:0]           cur_v_reg;
    logic [NW-1:0]           cur_w_reg;
    stk_entry_t              stk_rd_reg;
    logic                    res_reg;
    logic                    m_bip_reg;

    logic [NW-1:0] n_eff;
    logic [VW-1:0] start_v;
    logic [VW-1:0] w_idx;
    logic [VW-1:0] depth_m1;
    logic [VW-1:0] depth_m2;
    logic          edge_ok;
    logic          push_hit;
    logic          rd_en;
    logic [VW-1:0] rd_addr;

    assign n_eff    = (32'(vc_reg) > MAX_VERTICES) ? N_MAX : NW'(vc_reg);
    assign start_v  = start_reg[VW-1:0];
    assign w_idx    = cur_w_reg[VW-1:0];
    assign depth_m1 = VW'(depth_reg - NW'(1));
    assign depth_m2 = VW'(depth_reg - NW'(2));
    assign edge_ok  = (32'(s_first_vertex) < MAX_VERTICES)
                   && (32'(s_second_vertex) < MAX_VERTICES);

    assign status.clr_last      = (clr_addr_reg == CLR_END);
    assign status.start_done    = (start_reg >= n_eff);
    assign status.start_skip    = visited_reg[start_v];
    assign status.scan_end      = (cur_w_reg >= n_eff);
    assign status.scan_conflict = row_reg[w_idx] && visited_reg[w_idx]
                               && (color_reg[w_idx] == color_reg[cur_v_reg]);
    assign status.depth_one     = (depth_reg == NW'(1));
    assign status.out_busy      = m_valid_reg && !m_ready;

    assign push_hit = row_reg[w_idx] && !visited_reg[w_idx];
    assign rd_en    = cmd.start_visit || (cmd.scan_step && push_hit) || cmd.pop_load;

    always_comb begin
        priority if (cmd.pop_load) begin
            rd_addr = stk_rd_reg.v;
        end else if (cmd.start_visit) begin
            rd_addr = start_v;
        end else begin
            rd_addr = w_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            adj_mem[clr_addr_reg] <= '0;
        end else if (cmd.edge_first && edge_ok) begin
            adj_mem[VW'(s_first_vertex)][VW'(s_second_vertex)] <= 1'b1;
        end else if (cmd.edge_second && e_ok_reg) begin
            adj_mem[e_row_reg][e_col_reg] <= 1'b1;
        end
        if (rd_en) begin
            row_reg <= adj_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_step && push_hit) begin
            stk_mem[depth_m1] <= '{v: cur_v_reg, w: cur_w_reg + NW'(1)};
        end
        if (cmd.pop) begin
            stk_rd_reg <= stk_mem[depth_m2];
        end
    end

    assign m_valid_next = cmd.emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg       <= VC_RESET;
            clr_addr_reg <= '0;
            depth_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                vc_reg <= cfg_wdata;
            end
            if (cmd.clr_step) begin
                clr_addr_reg <= status.clr_last ? '0 : clr_addr_reg + VW'(1);
            end
            if (cmd.chk_start || cmd.pop_last) begin
                depth_reg <= '0;
            end else if (cmd.start_visit) begin
                depth_reg <= NW'(1);
            end else if (cmd.scan_step && push_hit) begin
                depth_reg <= depth_reg + NW'(1);
            end else if (cmd.pop) begin
                depth_reg <= depth_reg - NW'(1);
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.edge_first) begin
            e_row_reg <= VW'(s_second_vertex);
            e_col_reg <= VW'(s_first_vertex);
            e_ok_reg  <= edge_ok;
        end
        if (cmd.chk_start || cmd.clr_step) begin
            visited_reg <= '0;
            color_reg   <= '0;
        end
        if (cmd.chk_start) begin
            start_reg <= '0;
            res_reg   <= 1'b1;
        end
        if (cmd.start_next || cmd.pop_last) begin
            start_reg <= start_reg + NW'(1);
        end
        if (cmd.start_visit) begin
            visited_reg[start_v] <= 1'b1;
            color_reg[start_v]   <= 1'b1;
            cur_v_reg            <= start_v;
            cur_w_reg            <= '0;
        end
        if (cmd.scan_step) begin
            if (push_hit) begin
                visited_reg[w_idx] <= 1'b1;
                color_reg[w_idx]   <= ~color_reg[cur_v_reg];
                cur_v_reg          <= w_idx;
                cur_w_reg          <= '0;
            end else begin
                cur_w_reg <= cur_w_reg + NW'(1);
            end
        end
        if (cmd.conflict) begin
            res_reg <= 1'b0;
        end
        if (cmd.pop_load) begin
            cur_v_reg <= stk_rd_reg.v;
            cur_w_reg <= stk_rd_reg.w;
        end
        if (cmd.emit) begin
            m_bip_reg <= res_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_is_bipartite = m_bip_reg;

endmodule

`default_nettype wire

// File: hw/rtl/bgc_checker.sv
`default_nettype none

module bgc_checker (
    input wire aclk,
    input wire aresetn,
    input wire s_valid,
    input wire s_ready,
    input wire s_kind,
    input wire m_valid,
    input wire m_ready,
    input wire m_is_bipartite
);

    // A waiting result holds until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_is_bipartite))
        else $error("result changed while stalled");

    // An accepted check item keeps the input closed on the next cycle.
    a_check_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_kind |=> !s_ready)
        else $error("input reopened right after a check item");

    // An edge item keeps the input closed for the mirrored write.
    a_edge_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_kind |=> !s_ready)
        else $error("input reopened right after an edge item");

    // A new result is followed by the clearing pass, so the input is closed.
    a_result_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !s_ready)
        else $error("input open while the graph is being cleared");

endmodule

bind bipartite_graph_check bgc_checker u_bgc_checker (.*);

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top
    import bgc_pkg::*;
;

    localparam int STALL_LIMIT = 40000;
    localparam int LONG_HOLD   = 1000;
    localparam int SETTLE      = 100;
    localparam int ITEM_GOAL   = 1900;
    localparam int CALM_FROM   = 1700;

    typedef struct packed {
        logic       kind;
        logic [5:0] first_vertex;
        logic [5:0] second_vertex;
    } graph_item_t;

    class graph_scoreboard;
        logic [63:0] adjacency [64];
        logic [6:0]  vertex_count;
        bit          verdicts_due [$];
        int          verdicts_seen;
        int          mismatches;

        function new();
            foreach (adjacency[i]) adjacency[i] = '0;
            vertex_count  = VC_RESET;
            verdicts_seen = 0;
            mismatches    = 0;
        endfunction

        function void set_vertex_count(logic [6:0] value);
            vertex_count = value;
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction

        function void report(string what);
            $display("[%0t] graph check error: %s", $time, what);
            mismatches++;
        endfunction

        // Depth-first two-coloring of the subgraph induced by the checked vertices.
        function bit two_colorable();
            int          span;
            int          depth;
            int          v;
            int          w;
            logic [63:0] seen;
            logic [63:0] hue;
            int          walk_vertex [64];
            int          walk_next [64];
            span = (vertex_count > 7'd64) ? 64 : int'(vertex_count);
            seen = '0;
            hue  = '0;
            for (int s = 0; s < span; s++) begin
                if (!seen[s]) begin
                    seen[s]        = 1'b1;
                    hue[s]         = 1'b1;
                    walk_vertex[0] = s;
                    walk_next[0]   = 0;
                    depth          = 1;
                    while (depth > 0) begin
                        v = walk_vertex[depth - 1];
                        w = walk_next[depth - 1];
                        if (w >= span) begin
                            depth--;
                        end else begin
                            walk_next[depth - 1] = w + 1;
                            if (adjacency[v][w]) begin
                                if (!seen[w]) begin
                                    seen[w]            = 1'b1;
                                    hue[w]             = ~hue[v];
                                    walk_vertex[depth] = w;
                                    walk_next[depth]   = 0;
                                    depth++;
                                end else if (hue[w] == hue[v]) begin
                                    return 1'b0;
                                end
                            end
                        end
                    end
                end
            end
            return 1'b1;
        endfunction

        function void note_item(graph_item_t item);
            if (item.kind == KIND_EDGE) begin
                adjacency[item.first_vertex][item.second_vertex] = 1'b1;
                adjacency[item.second_vertex][item.first_vertex] = 1'b1;
            end else begin
                verdicts_due = {verdicts_due, two_colorable()};
                foreach (adjacency[i]) adjacency[i] = '0;
            end
        endfunction

        function void check_result(logic is_bipartite);
            bit want;
            if (verdicts_due.size() == 0) begin
                report("result arrived with no check pending");
            end else begin
                want = verdicts_due.pop_front();
                verdicts_seen++;
                if (is_bipartite !== want) begin
                    report($sformatf("verdict %0d: is_bipartite %b, predicted %b",
                                     verdicts_seen, is_bipartite, want));
                end
            end
        endfunction
    endclass

    logic       aclk            = 1'b0;
    logic       aresetn         = 1'b0;
    logic       cfg_we          = 1'b0;
    logic [6:0] cfg_wdata       = '0;
    logic       s_valid         = 1'b0;
    logic       s_ready;
    logic       s_kind          = KIND_EDGE;
    logic [5:0] s_first_vertex  = '0;
    logic [5:0] s_second_vertex = '0;
    logic       m_valid;
    logic       m_ready         = 1'b0;
    logic       m_is_bipartite;

    graph_scoreboard sb = new();
    int  items_sent  = 0;
    int  quiet_count = 0;
    bit  calm        = 1'b0;
    bit  hold_req    = 1'b0;

    always #2 aclk = ~aclk;

    bipartite_graph_check #(
        .MAX_VERTICES(64)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_kind(s_kind),
        .s_first_vertex(s_first_vertex),
        .s_second_vertex(s_second_vertex),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_is_bipartite(m_is_bipartite)
    );

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.check_result(m_is_bipartite);
            end
            if (s_valid && s_ready) begin
                sb.note_item({s_kind, s_first_vertex, s_second_vertex});
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                quiet_count = 0;
            end else begin
                quiet_count++;
            end
            if (quiet_count >= STALL_LIMIT) begin
                $display("bipartite_graph_check: mismatch");
                $finish;
            end
        end
    end

    task automatic send_item(input logic kind, input logic [5:0] a, input logic [5:0] b);
        s_valid         <= 1'b1;
        s_kind          <= kind;
        s_first_vertex  <= a;
        s_second_vertex <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_check();
        send_item(KIND_CHECK, 6'($urandom), 6'($urandom));
    endtask

    task automatic sender_gap(input int pct);
        if (!calm && $urandom_range(0, 99) < pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    // The block is idle once every verdict is in and the clearing pass has ended.
    task automatic quiesce();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_vertex_count(input logic [6:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.set_vertex_count(value);
        cfg_we    <= 1'b0;
    endtask

    // Mostly edges that respect a random two-sided split, so the walk covers whole
    // components; some graphs carry one edge that breaks the split.
    task automatic send_graph(input int span, input int pct);
        logic [63:0] side;
        int          edges;
        int          broken_at;
        int          tries;
        bit          want_same;
        logic [5:0]  a;
        logic [5:0]  b;
        side      = {$urandom, $urandom};
        edges     = $urandom_range(1, (span < 4) ? 4 : ((span > 24) ? 48 : 2 * span));
        broken_at = ($urandom_range(0, 1) == 0) ? -1 : $urandom_range(0, edges - 1);
        for (int i = 0; i < edges; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                a = 6'($urandom);
                b = 6'($urandom);
            end else begin
                want_same = (i == broken_at);
                a         = 6'($urandom_range(0, span - 1));
                b         = 6'($urandom_range(0, span - 1));
                tries     = 0;
                while (((side[a] == side[b]) != want_same) && tries < 8) begin
                    b = 6'($urandom_range(0, span - 1));
                    tries++;
                end
            end
            send_item(KIND_EDGE, a, b);
            sender_gap(pct);
        end
        send_check();
        sender_gap(pct);
    endtask

    initial begin
        bit held;
        held = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && hold_req) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (calm) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else if ($urandom_range(0, 3) != 0) begin
                m_ready <= 1'b1;
                repeat (($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 8))
                    @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    initial begin
        int         r;
        int         pct;
        int         span;
        int         graphs;
        logic [6:0] count;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(KIND_EDGE, 6'd0, 6'd63);
        send_item(KIND_EDGE, 6'd63, 6'd62);
        send_item(KIND_EDGE, 6'd62, 6'd0);
        send_check();
        send_check();
        send_item(KIND_EDGE, 6'd5, 6'd5);
        send_check();
        send_item(KIND_EDGE, 6'd0, 6'd1);
        send_item(KIND_EDGE, 6'd1, 6'd2);
        send_item(KIND_EDGE, 6'd2, 6'd3);
        send_item(KIND_EDGE, 6'd3, 6'd0);
        send_check();
        quiesce();
        write_vertex_count(7'd0);
        send_item(KIND_EDGE, 6'd0, 6'd0);
        send_check();
        quiesce();
        write_vertex_count(7'd127);
        send_item(KIND_EDGE, 6'd63, 6'd63);
        send_check();
        quiesce();
        write_vertex_count(7'd3);
        send_item(KIND_EDGE, 6'd3, 6'd4);
        send_item(KIND_EDGE, 6'd4, 6'd5);
        send_item(KIND_EDGE, 6'd5, 6'd3);
        send_item(KIND_EDGE, 6'd0, 6'd1);
        send_item(KIND_EDGE, 6'd1, 6'd2);
        send_check();

        // Several checks in a row against a held receiver fill the block up.
        quiesce();
        write_vertex_count(7'd8);
        span     = 8;
        hold_req = 1'b1;
        repeat (4) send_graph(8, 0);

        while (items_sent < ITEM_GOAL) begin
            if (!calm) begin
                quiesce();
                r = $urandom_range(0, 99);
                if (r < 5) count = 7'd0;
                else if (r < 10) count = 7'd1;
                else if (r < 16) count = 7'd64;
                else if (r < 22) count = 7'($urandom_range(65, 127));
                else if (r < 25) count = 7'd127;
                else if (r < 80) count = 7'($urandom_range(2, 12));
                else count = 7'($urandom_range(13, 40));
                write_vertex_count(count);
                span   = (count == 7'd0 || count > 7'd64) ? 64 : int'(count);
                r      = $urandom_range(0, 2);
                pct    = (r == 0) ? 0 : ((r == 1) ? 15 : 40);
                graphs = $urandom_range(1, 5);
            end else begin
                pct    = 0;
                graphs = 1;
            end
            for (int g = 0; g < graphs; g++) begin
                send_graph(span, pct);
                if (items_sent >= CALM_FROM) calm = 1'b1;
                if (items_sent >= ITEM_GOAL) break;
            end
        end

        quiesce();
        if (sb.mismatches == 0) begin
            $display("bipartite_graph_check: match");
        end else begin
            $display("bipartite_graph_check: mismatch");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/bgc_pkg.sv
hw/rtl/bgc_ctrl.sv
hw/rtl/bgc_dp.sv
hw/rtl/bipartite_graph_check.sv
hw/rtl/bgc_checker.sv
tb/sv/tb_top.sv
